// ===== rtl/fresnel_reflect_fraction_macros.svh =====
// Assertion macros for fresnel_reflect_fraction
`ifndef FRESNEL_REFLECT_FRACTION_MACROS_SVH
`define FRESNEL_REFLECT_FRACTION_MACROS_SVH
`ifndef NO_ASSERTIONS
`define FRF_ASSERT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("fresnel_reflect_fraction assertion failed");
`define FRF_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("fresnel_reflect_fraction assertion failed");
`else
`define FRF_ASSERT(lbl, ante, cons)
`define FRF_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// ===== rtl/frf_pkg.sv =====
`timescale 1ns / 1ps
package frf_pkg;

  localparam logic [15:0] ONE_Q15 = 16'd32768;
  localparam int SDIV_STEPS = 31;
  localparam int QDIV_STEPS = 16;
  localparam int SQRT_STEPS = 16;
  localparam int FRONT_STAGES = 4;
  localparam int BACK_STAGES = 6;
  localparam int NSTAGE = FRONT_STAGES + SDIV_STEPS + 1 + SQRT_STEPS + BACK_STAGES;

  typedef struct packed {
    logic        gt;
    logic        tir;
    logic        zsum;
    logic [15:0] c;
    logic [15:0] refl;
    logic [15:0] q;
  } carry_t;

  function automatic logic [15:0] mul_q15(input logic [15:0] a, input logic [15:0] b);
    logic [32:0] p;
    p = 33'(a) * 33'(b) + 33'd16384;
    return p[30:15];
  endfunction

  function automatic logic [15:0] sat_add(input logic [15:0] a, input logic [15:0] b);
    logic [16:0] s;
    s = 17'(a) + 17'(b);
    return (s > 17'(ONE_Q15)) ? ONE_Q15 : s[15:0];
  endfunction

endpackage

// ===== rtl/fresnel_reflect_fraction.sv =====
`timescale 1ns / 1ps
`include "fresnel_reflect_fraction_macros.svh"
// Schlick reflected fraction in fixed point. One request enters per cycle and
// passes through a bit-serial pipelined divider for the squared refracted sine
// (31 stages, with the index-ratio divider running alongside in its first 16),
// a 16-stage square root and six multiply stages. A stalled output holds the
// whole pipeline.
module fresnel_reflect_fraction (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [15:0] normal_x,
  input  logic signed [15:0] normal_y,
  input  logic signed [15:0] normal_z,
  input  logic signed [15:0] dir_x,
  input  logic signed [15:0] dir_y,
  input  logic signed [15:0] dir_z,
  input  logic [15:0]        base_reflectivity,
  input  logic [15:0]        index_incident,
  input  logic [15:0]        index_transmitted,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [15:0]        reflected_fraction,
  output logic               total_internal
);

  logic adv;
  logic [frf_pkg::NSTAGE-1:0] vld;

  assign adv = !out_valid || out_ready;
  assign in_ready = adv;
  assign out_valid = vld[frf_pkg::NSTAGE-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[frf_pkg::NSTAGE-2:0], in_valid};
    end
  end

  // stage 1: products
  logic signed [31:0] s1_px, s1_py, s1_pz;
  logic [31:0] s1_n1sq, s1_n2sq;
  logic [15:0] s1_diff, s1_refl;
  logic [16:0] s1_sum;
  logic        s1_gt;

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_px   <= normal_x * dir_x;
      s1_py   <= normal_y * dir_y;
      s1_pz   <= normal_z * dir_z;
      s1_n1sq <= 32'(index_incident) * 32'(index_incident);
      s1_n2sq <= 32'(index_transmitted) * 32'(index_transmitted);
      s1_gt   <= index_incident > index_transmitted;
      s1_diff <= (index_incident > index_transmitted) ?
                 (index_incident - index_transmitted) : (index_transmitted - index_incident);
      s1_sum  <= 17'(index_incident) + 17'(index_transmitted);
      s1_refl <= (base_reflectivity > frf_pkg::ONE_Q15) ? frf_pkg::ONE_Q15 : base_reflectivity;
    end
  end

  // stage 2: cosine and ratio numerator
  logic signed [33:0] dot;
  logic [33:0] adot, cr;
  logic [15:0] s2_c, s2_refl;
  logic [31:0] s2_qn, s2_n1sq, s2_n2sq;
  logic [16:0] s2_sum;
  logic        s2_gt;

  always_comb begin
    dot  = 34'(s1_px) + 34'(s1_py) + 34'(s1_pz);
    adot = dot[33] ? 34'(-dot) : 34'(dot);
    cr   = (adot + 34'd4096) >> 13;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_c    <= (cr > 34'(frf_pkg::ONE_Q15)) ? frf_pkg::ONE_Q15 : cr[15:0];
      s2_qn   <= {1'b0, s1_diff, 15'd0} + 32'(s1_sum[16:1]);
      s2_sum  <= s1_sum;
      s2_n1sq <= s1_n1sq;
      s2_n2sq <= s1_n2sq;
      s2_gt   <= s1_gt;
      s2_refl <= s1_refl;
    end
  end

  // stage 3: c squared
  logic [31:0] s3_c2, s3_qn, s3_n1sq, s3_n2sq;
  logic [15:0] s3_c, s3_refl;
  logic [16:0] s3_sum;
  logic        s3_gt;

  always_ff @(posedge clk) begin
    if (adv) begin
      s3_c2   <= 32'(s2_c) * 32'(s2_c);
      s3_c    <= s2_c;
      s3_qn   <= s2_qn;
      s3_sum  <= s2_sum;
      s3_n1sq <= s2_n1sq;
      s3_n2sq <= s2_n2sq;
      s3_gt   <= s2_gt;
      s3_refl <= s2_refl;
    end
  end

  // stage 4: n1^2 (1 - c^2)
  logic [31:0] omc2;
  logic [61:0] s4_num;
  logic [31:0] s4_qn, s4_n2sq;
  logic [16:0] s4_sum;
  frf_pkg::carry_t s4_ca;

  assign omc2 = 32'h4000_0000 - s3_c2;

  always_ff @(posedge clk) begin
    if (adv) begin
      s4_num       <= {30'd0, s3_n1sq} * {31'd0, omc2[30:0]};
      s4_qn        <= s3_qn;
      s4_sum       <= s3_sum;
      s4_n2sq      <= s3_n2sq;
      s4_ca.gt     <= s3_gt;
      s4_ca.tir    <= 1'b0;
      s4_ca.zsum   <= (s3_sum == 17'd0);
      s4_ca.c      <= s3_c;
      s4_ca.refl   <= s3_refl;
      s4_ca.q      <= '0;
    end
  end

  // divider stages: sine squared and index ratio
  logic [31:0] d_rem [frf_pkg::SDIV_STEPS+1];
  logic [30:0] d_num [frf_pkg::SDIV_STEPS+1];
  logic [30:0] d_quo [frf_pkg::SDIV_STEPS+1];
  logic [31:0] d_den [frf_pkg::SDIV_STEPS+1];
  logic [16:0] q_rem [frf_pkg::SDIV_STEPS+1];
  logic [15:0] q_num [frf_pkg::SDIV_STEPS+1];
  logic [15:0] q_quo [frf_pkg::SDIV_STEPS+1];
  logic [16:0] q_den [frf_pkg::SDIV_STEPS+1];
  frf_pkg::carry_t d_ca [frf_pkg::SDIV_STEPS+1];
  frf_pkg::carry_t d0_ca;

  always_comb begin
    d0_ca     = s4_ca;
    d0_ca.tir = s4_ca.gt && (s4_num > {s4_n2sq, 30'd0});
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      d_rem[0]     <= {1'b0, s4_num[61:31]};
      d_num[0]     <= s4_num[30:0];
      d_quo[0]     <= '0;
      d_den[0]     <= s4_n2sq;
      q_rem[0]     <= {1'b0, s4_qn[31:16]};
      q_num[0]     <= s4_qn[15:0];
      q_quo[0]     <= '0;
      q_den[0]     <= s4_sum;
      d_ca[0]      <= d0_ca;
    end
  end

  for (genvar j = 1; j <= frf_pkg::SDIV_STEPS; j++) begin : g_div
    logic [32:0] r2;
    logic        ge;
    logic [17:0] qr2;
    logic        qge;

    always_comb begin
      r2  = {d_rem[j-1], d_num[j-1][30]};
      ge  = r2 >= {1'b0, d_den[j-1]};
      qr2 = {q_rem[j-1], q_num[j-1][15]};
      qge = qr2 >= {1'b0, q_den[j-1]};
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        d_rem[j] <= ge ? 32'(r2 - {1'b0, d_den[j-1]}) : r2[31:0];
        d_num[j] <= d_num[j-1] << 1;
        d_quo[j] <= {d_quo[j-1][29:0], ge};
        d_den[j] <= d_den[j-1];
        q_den[j] <= q_den[j-1];
        d_ca[j]  <= d_ca[j-1];
        if (j <= frf_pkg::QDIV_STEPS) begin
          q_rem[j] <= qge ? 17'(qr2 - {1'b0, q_den[j-1]}) : qr2[16:0];
          q_num[j] <= q_num[j-1] << 1;
          q_quo[j] <= {q_quo[j-1][14:0], qge};
        end else begin
          q_rem[j] <= q_rem[j-1];
          q_num[j] <= q_num[j-1];
          q_quo[j] <= q_quo[j-1];
        end
      end
    end
  end

  // square root stages: refracted cosine
  logic [19:0] sq_rem  [frf_pkg::SQRT_STEPS];
  logic [15:0] sq_root [frf_pkg::SQRT_STEPS];
  logic [31:0] sq_x    [frf_pkg::SQRT_STEPS];
  frf_pkg::carry_t sq_ca [frf_pkg::SQRT_STEPS];

  logic [30:0] s_fin;
  logic [31:0] v_fin;

  assign s_fin = (d_den[frf_pkg::SDIV_STEPS] == 32'd0) ? 31'd0 : d_quo[frf_pkg::SDIV_STEPS];
  assign v_fin = 32'h4000_0000 - {1'b0, s_fin};

  for (genvar i = 0; i < frf_pkg::SQRT_STEPS; i++) begin : g_sqrt
    logic [19:0] rin, rs, trial;
    logic [15:0] root_in;
    logic [31:0] x_in;
    frf_pkg::carry_t ca_in;
    logic        ge;

    if (i == 0) begin : g_first
      always_comb begin
        rin     = '0;
        root_in = '0;
        x_in    = v_fin;
        ca_in   = d_ca[frf_pkg::SDIV_STEPS];
        ca_in.q = q_quo[frf_pkg::SDIV_STEPS];
      end
    end else begin : g_rest
      always_comb begin
        rin     = sq_rem[i-1];
        root_in = sq_root[i-1];
        x_in    = sq_x[i-1];
        ca_in   = sq_ca[i-1];
      end
    end

    always_comb begin
      rs    = {rin[17:0], x_in[31:30]};
      trial = {2'b00, root_in, 2'b01};
      ge    = rs >= trial;
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        sq_rem[i]  <= ge ? (rs - trial) : rs;
        sq_root[i] <= {root_in[14:0], ge};
        sq_x[i]    <= x_in << 2;
        sq_ca[i]   <= ca_in;
      end
    end
  end

  // back end: Schlick term and blend
  logic [15:0] root_f, cf, qf;
  logic [15:0] b0_t, b0_r0, b1_t, b1_t2, b1_r0, b2_t, b2_t4, b2_r0, b3_t5, b3_r0, b4_fres;
  logic [15:0] b0_refl, b1_refl, b2_refl, b3_refl, b4_refl;
  logic        b0_tir, b1_tir, b2_tir, b3_tir, b4_tir;
  frf_pkg::carry_t ca_l;

  assign ca_l   = sq_ca[frf_pkg::SQRT_STEPS-1];
  assign root_f = sq_root[frf_pkg::SQRT_STEPS-1];
  assign cf     = ca_l.gt ? ((root_f > frf_pkg::ONE_Q15) ? frf_pkg::ONE_Q15 : root_f) : ca_l.c;
  assign qf     = (ca_l.q > frf_pkg::ONE_Q15) ? frf_pkg::ONE_Q15 : ca_l.q;

  always_ff @(posedge clk) begin
    if (adv) begin
      b0_t    <= frf_pkg::ONE_Q15 - cf;
      b0_r0   <= ca_l.zsum ? 16'd0 : frf_pkg::mul_q15(qf, qf);
      b0_refl <= ca_l.refl;
      b0_tir  <= ca_l.tir;

      b1_t2   <= frf_pkg::mul_q15(b0_t, b0_t);
      b1_t    <= b0_t;
      b1_r0   <= b0_r0;
      b1_refl <= b0_refl;
      b1_tir  <= b0_tir;

      b2_t4   <= frf_pkg::mul_q15(b1_t2, b1_t2);
      b2_t    <= b1_t;
      b2_r0   <= b1_r0;
      b2_refl <= b1_refl;
      b2_tir  <= b1_tir;

      b3_t5   <= frf_pkg::mul_q15(b2_t4, b2_t);
      b3_r0   <= b2_r0;
      b3_refl <= b2_refl;
      b3_tir  <= b2_tir;

      b4_fres <= frf_pkg::sat_add(b3_r0, frf_pkg::mul_q15(frf_pkg::ONE_Q15 - b3_r0, b3_t5));
      b4_refl <= b3_refl;
      b4_tir  <= b3_tir;

      reflected_fraction <= b4_tir ? frf_pkg::ONE_Q15 :
        frf_pkg::sat_add(b4_refl, frf_pkg::mul_q15(frf_pkg::ONE_Q15 - b4_refl, b4_fres));
      total_internal <= b4_tir;
    end
  end

  `FRF_ASSERT(a_tir_full, out_valid && total_internal, reflected_fraction == frf_pkg::ONE_Q15)
  `FRF_ASSERT(a_sat, out_valid, reflected_fraction <= frf_pkg::ONE_Q15)
  `FRF_ASSERT(a_tir_gt, vld[frf_pkg::FRONT_STAGES] && d_ca[0].tir, d_ca[0].gt)
  `FRF_ASSERT_NEXT(a_hold, out_valid && !out_ready, out_valid && $stable(reflected_fraction))

endmodule
